// ===== src/rewr_pkg.sv =====
// Shared types and constants for the reverse equal-weight rebinning block.
package rewr_pkg;

  localparam int unsigned MaxBins  = 1024;
  localparam int unsigned BinAw    = $clog2(MaxBins);
  localparam int unsigned CntW     = $clog2(MaxBins + 2);
  localparam int unsigned EdgeAw   = $clog2(MaxBins + 1);
  localparam int unsigned EdgeDepth = MaxBins + 1;
  localparam int unsigned WeightW  = 32;
  localparam int unsigned TotalW   = WeightW + BinAw;
  localparam int unsigned GroupW   = 11;
  localparam int unsigned ProdW    = TotalW + GroupW;
  localparam int unsigned FracW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [GroupW-1:0]  TargetGroupsReset = GroupW'(20);
  localparam logic [WeightW-1:0] SmallLimitReset   = WeightW'(655360);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_GROUPS = 2'd0,
    CFG_REVISE_TARGET = 2'd1,
    CFG_USE_COUNT     = 2'd2,
    CFG_SMALL_LIMIT   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_READ  = 10'b00_0000_0010,
    S_PMUL  = 10'b00_0000_0100,
    S_PCHK  = 10'b00_0000_1000,
    S_PTAIL = 10'b00_0001_0000,
    S_GRP   = 10'b00_0010_0000,
    S_ACC   = 10'b00_0100_0000,
    S_MUL   = 10'b00_1000_0000,
    S_CMP   = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_e;

endpackage

// ===== src/reverse_equal_weight_rebinning.sv =====
// Top level: equal-weight histogram rebinning, groups built from the top bin down.
//
// Bin weights (unsigned, 16 fraction bits) are loaded one word per item in
// ascending bin order into a 1024 x 32 bin memory; the word flagged last_bin
// starts the merge pass. A load item that ends no histogram is answered in the
// cycle after it is taken, so loads stream at one word per cycle while the
// consumer keeps up. A read item passes through the edge memory's registered
// read port and then the result word, and no other item is taken meanwhile.
// The merge pass walks the bin memory through its single read port: setup in
// S_PMUL and S_PCHK, S_GRP at the start of each group, then per bin a read,
// S_ACC (accumulate), S_MUL and S_CMP (multiply and compare through one 42x11
// multiplier) and the closing S_FIN; a histogram too light for two groups
// closes in S_PTAIL after S_PCHK. Edges are stored high to low in the edge
// memory and read back ascending, so slot 0 is always bin index 0. No item is
// taken while a pass runs; configuration must be written only while idle.
module reverse_equal_weight_rebinning (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [rewr_pkg::WeightW-1:0]      bin_weight_i,
  input  logic                              last_bin_i,
  input  logic [rewr_pkg::CntW-1:0]         edge_slot_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rewr_pkg::CntW-1:0]         bins_loaded_o,
  output logic                              done_res_o,
  output logic [rewr_pkg::CntW-1:0]         edge_count_o,
  output logic [rewr_pkg::CntW-1:0]         edge_bin_o,
  output logic                              edge_valid_o,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [rewr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rewr_pkg::CfgDataW-1:0]     cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [rewr_pkg::GroupW-1:0]  tgt_groups_q;
  logic                         revise_q;
  logic                         use_count_q;
  logic [rewr_pkg::WeightW-1:0] small_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_groups_q  <= rewr_pkg::TargetGroupsReset;
      revise_q      <= 1'b0;
      use_count_q   <= 1'b0;
      small_limit_q <= rewr_pkg::SmallLimitReset;
    end else if (cfg_we_i) begin
      case (rewr_pkg::cfg_idx_e'(cfg_index_i))
        rewr_pkg::CFG_TARGET_GROUPS: tgt_groups_q  <= cfg_data_i[rewr_pkg::GroupW-1:0];
        rewr_pkg::CFG_REVISE_TARGET: revise_q      <= cfg_data_i[0];
        rewr_pkg::CFG_USE_COUNT:     use_count_q   <= cfg_data_i[0];
        rewr_pkg::CFG_SMALL_LIMIT:   small_limit_q <= cfg_data_i[rewr_pkg::WeightW-1:0];
        default: ;
      endcase
    end
  end

  // Share mode divides the weight by the group count; the ratio is never
  // formed, every compare is cross-multiplied by den.
  logic                        share_c;
  logic [rewr_pkg::GroupW-1:0] den_c;
  assign share_c = revise_q || !use_count_q;
  always_comb begin
    den_c = rewr_pkg::GroupW'(1);
    if (share_c && (tgt_groups_q != '0)) begin
      den_c = tgt_groups_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic [rewr_pkg::WeightW-1:0] bin_store [rewr_pkg::MaxBins];
  logic                         bin_we;
  logic [rewr_pkg::BinAw-1:0]   bin_waddr;
  logic [rewr_pkg::BinAw-1:0]   bin_raddr;
  logic [rewr_pkg::WeightW-1:0] bin_rdata_q;

  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_store[bin_waddr] <= bin_weight_i;
    end
    bin_rdata_q <= bin_store[bin_raddr];
  end

  logic [rewr_pkg::CntW-1:0]   edge_store [rewr_pkg::EdgeDepth];
  logic                        edge_we;
  logic [rewr_pkg::EdgeAw-1:0] edge_waddr;
  logic [rewr_pkg::CntW-1:0]   edge_wdata;
  logic [rewr_pkg::EdgeAw-1:0] edge_raddr;
  logic [rewr_pkg::CntW-1:0]   edge_rdata_q;

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_store[edge_waddr] <= edge_wdata;
    end
    edge_rdata_q <= edge_store[edge_raddr];
  end

  // ---------------------------------------------------------------------------
  // Control and datapath state
  // ---------------------------------------------------------------------------
  rewr_pkg::state_e              state_q, state_d;
  logic [rewr_pkg::CntW-1:0]     loaded_q, loaded_d;     // bins held
  logic [rewr_pkg::TotalW-1:0]   total_q, total_d;       // sum of all bins
  logic [rewr_pkg::CntW-1:0]     edges_q, edges_d;       // edges of last pass
  logic [rewr_pkg::CntW-1:0]     idx_q, idx_d;           // walk position, bins left
  logic [rewr_pkg::CntW-1:0]     cnt_q, cnt_d;           // edges written so far
  logic [rewr_pkg::TotalW-1:0]   remain_q, remain_d;     // weight not yet grouped
  logic [rewr_pkg::TotalW-1:0]   sum_q, sum_d;           // weight of current group
  logic [rewr_pkg::TotalW-1:0]   num_q, num_d;           // target numerator
  logic [rewr_pkg::ProdW-1:0]    prod_q, prod_d;
  logic                          first_q, first_d;       // first bin of a group
  logic                          rd_hit_q, rd_hit_d;

  // result word
  logic                          out_valid_q;
  logic                          out_load;
  logic [rewr_pkg::CntW-1:0]     bins_q, bins_d;
  logic                          done_q, done_d;
  logic [rewr_pkg::CntW-1:0]     ecount_q, ecount_d;
  logic [rewr_pkg::CntW-1:0]     ebin_q, ebin_d;
  logic                          evalid_q, evalid_d;

  logic                          in_acc;
  logic [rewr_pkg::CntW-1:0]     base_cnt;
  logic [rewr_pkg::TotalW-1:0]   base_tot;
  logic [rewr_pkg::TotalW-1:0]   mul_a;
  logic                          more;
  logic                          merge_last;
  logic [rewr_pkg::CntW-1:0]     fin_cnt;

  assign in_ready_o = (state_q == rewr_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  // A load after a finished pass starts a new histogram.
  assign base_cnt = (edges_q != '0) ? '0 : loaded_q;
  assign base_tot = (edges_q != '0) ? '0 : total_q;

  // One shared multiplier: total for the light-histogram test, else group sum.
  assign mul_a = (state_q == rewr_pkg::S_PMUL) ? total_q : sum_q;

  // First bin of a group closes it only when it passes the target; later bins
  // when they reach it.
  assign more = first_q ? (prod_q <= rewr_pkg::ProdW'(num_q))
                        : (prod_q <  rewr_pkg::ProdW'(num_q));

  assign merge_last = (cnt_q > rewr_pkg::CntW'(2)) &&
                      (sum_q < rewr_pkg::TotalW'(small_limit_q));
  assign fin_cnt    = merge_last ? (cnt_q - rewr_pkg::CntW'(1)) : cnt_q;

  always_comb begin
    state_d    = state_q;
    loaded_d   = loaded_q;
    total_d    = total_q;
    edges_d    = edges_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    remain_d   = remain_q;
    sum_d      = sum_q;
    num_d      = num_q;
    prod_d     = rewr_pkg::ProdW'(mul_a) * rewr_pkg::ProdW'(den_c);
    first_d    = first_q;
    rd_hit_d   = rd_hit_q;
    bin_we     = 1'b0;
    bin_waddr  = base_cnt[rewr_pkg::BinAw-1:0];
    bin_raddr  = rewr_pkg::BinAw'(idx_q - rewr_pkg::CntW'(1));
    edge_we    = 1'b0;
    edge_waddr = cnt_q[rewr_pkg::EdgeAw-1:0];
    edge_wdata = idx_q - rewr_pkg::CntW'(1);
    edge_raddr = rewr_pkg::EdgeAw'(edges_q - rewr_pkg::CntW'(1) - edge_slot_i);
    out_load   = 1'b0;
    bins_d     = loaded_q;
    done_d     = (edges_q != '0);
    ecount_d   = edges_q;
    ebin_d     = '0;
    evalid_d   = 1'b0;

    case (state_q)
      rewr_pkg::S_IDLE: begin
        if (in_acc) begin
          if (rewr_pkg::op_e'(op_i) == rewr_pkg::OP_LOAD) begin
            edges_d  = '0;
            loaded_d = base_cnt;
            total_d  = base_tot;
            if (base_cnt != rewr_pkg::CntW'(rewr_pkg::MaxBins)) begin
              bin_we   = 1'b1;
              loaded_d = base_cnt + rewr_pkg::CntW'(1);
              total_d  = base_tot + rewr_pkg::TotalW'(bin_weight_i);
            end
            if (last_bin_i) begin
              state_d = rewr_pkg::S_PMUL;
            end else begin
              out_load = 1'b1;
              bins_d   = loaded_d;
              done_d   = 1'b0;
              ecount_d = '0;
            end
          end else begin
            rd_hit_d = (edge_slot_i < edges_q);
            state_d  = rewr_pkg::S_READ;
          end
        end
      end
      rewr_pkg::S_READ: begin
        out_load = 1'b1;
        ebin_d   = rd_hit_q ? edge_rdata_q : '0;
        evalid_d = rd_hit_q;
        state_d  = rewr_pkg::S_IDLE;
      end
      rewr_pkg::S_PMUL: begin
        // prod_d = total * den
        num_d   = share_c ? total_q
                          : rewr_pkg::TotalW'({tgt_groups_q, {rewr_pkg::FracW{1'b0}}});
        state_d = rewr_pkg::S_PCHK;
      end
      rewr_pkg::S_PCHK: begin
        // the top edge always comes first
        edge_we    = 1'b1;
        edge_waddr = '0;
        edge_wdata = loaded_q;
        if (prod_q < rewr_pkg::ProdW'({num_q, 1'b0})) begin
          state_d = rewr_pkg::S_PTAIL;
        end else begin
          cnt_d    = rewr_pkg::CntW'(1);
          idx_d    = loaded_q;
          remain_d = total_q;
          state_d  = rewr_pkg::S_GRP;
        end
      end
      rewr_pkg::S_PTAIL: begin
        // too light for two groups: outer edges only
        edge_we    = 1'b1;
        edge_waddr = rewr_pkg::EdgeAw'(1);
        edge_wdata = '0;
        edges_d    = rewr_pkg::CntW'(2);
        out_load   = 1'b1;
        done_d     = 1'b1;
        ecount_d   = rewr_pkg::CntW'(2);
        state_d    = rewr_pkg::S_IDLE;
      end
      rewr_pkg::S_GRP: begin
        if (revise_q) begin
          num_d = remain_q;
        end
        first_d = 1'b1;
        state_d = rewr_pkg::S_ACC;
      end
      rewr_pkg::S_ACC: begin
        sum_d   = (first_q ? '0 : sum_q) + rewr_pkg::TotalW'(bin_rdata_q);
        state_d = rewr_pkg::S_MUL;
      end
      rewr_pkg::S_MUL: begin
        state_d = rewr_pkg::S_CMP;
      end
      rewr_pkg::S_CMP: begin
        if (more && (idx_q > rewr_pkg::CntW'(1))) begin
          idx_d     = idx_q - rewr_pkg::CntW'(1);
          bin_raddr = rewr_pkg::BinAw'(idx_q - rewr_pkg::CntW'(2));
          first_d   = 1'b0;
          state_d   = rewr_pkg::S_ACC;
        end else begin
          // group closes at the low edge of the bin just taken
          edge_we  = 1'b1;
          cnt_d    = cnt_q + rewr_pkg::CntW'(1);
          remain_d = remain_q - sum_q;
          idx_d    = idx_q - rewr_pkg::CntW'(1);
          state_d  = (idx_q == rewr_pkg::CntW'(1)) ? rewr_pkg::S_FIN : rewr_pkg::S_GRP;
        end
      end
      rewr_pkg::S_FIN: begin
        // light bottom group joins the one above: its upper edge becomes zero
        if (merge_last) begin
          edge_we    = 1'b1;
          edge_waddr = rewr_pkg::EdgeAw'(cnt_q - rewr_pkg::CntW'(2));
          edge_wdata = '0;
        end
        cnt_d    = fin_cnt;
        edges_d  = fin_cnt;
        out_load = 1'b1;
        done_d   = 1'b1;
        ecount_d = fin_cnt;
        state_d  = rewr_pkg::S_IDLE;
      end
      default: begin
        state_d = rewr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rewr_pkg::S_IDLE;
      loaded_q    <= '0;
      total_q     <= '0;
      edges_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      total_q  <= total_d;
      edges_q  <= edges_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    remain_q <= remain_d;
    sum_q    <= sum_d;
    num_q    <= num_d;
    prod_q   <= prod_d;
    first_q  <= first_d;
    rd_hit_q <= rd_hit_d;
    if (out_load) begin
      bins_q   <= bins_d;
      done_q   <= done_d;
      ecount_q <= ecount_d;
      ebin_q   <= ebin_d;
      evalid_q <= evalid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bins_loaded_o = bins_q;
  assign done_res_o    = done_q;
  assign edge_count_o  = ecount_q;
  assign edge_bin_o    = ebin_q;
  assign edge_valid_o  = evalid_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic in_pass;
  assign in_pass = (state_q == rewr_pkg::S_PMUL) || (state_q == rewr_pkg::S_PCHK) ||
                   (state_q == rewr_pkg::S_PTAIL) || (state_q == rewr_pkg::S_GRP) ||
                   (state_q == rewr_pkg::S_ACC) || (state_q == rewr_pkg::S_MUL) ||
                   (state_q == rewr_pkg::S_CMP) || (state_q == rewr_pkg::S_FIN);

  a_pass_edges_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pass |-> (edges_q == '0) && (loaded_q != '0))
    else $error("edge count not clear or no bins during pass");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rewr_pkg::S_CMP) |-> (idx_q != '0) && (idx_q <= loaded_q))
    else $error("walk position out of range");

  a_edge_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rewr_pkg::S_FIN) |-> (cnt_q >= rewr_pkg::CntW'(2)) &&
                                     (cnt_q <= loaded_q + rewr_pkg::CntW'(1)))
    else $error("edge count out of bounds at end of pass");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_ready_i)
    else $error("result word overwritten before it was taken");

  a_valid_edge_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && evalid_q) |-> done_q && (ecount_q >= rewr_pkg::CntW'(2)))
    else $error("valid edge without a finished pass");

endmodule

// ===== tb/sv/reverse_equal_weight_rebinning_tb.sv =====
// Self-checking testbench for the reverse equal-weight rebinning block.
`timescale 1ns / 1ps

module reverse_equal_weight_rebinning_tb;

  // quiet cycles (no word taken on either side) before the run is declared hung;
  // the longest correct quiet stretch is one merge pass over a full store
  localparam int unsigned StallLimit = 50000;
  localparam int unsigned ItemTarget = 1850;
  localparam int unsigned MaxSlot    = (1 << rewr_pkg::CntW) - 1;

  // one input word and one result word as seen at the ports
  typedef struct packed {
    rewr_pkg::op_e                op;
    logic [rewr_pkg::WeightW-1:0] weight;
    logic                         last;
    logic [rewr_pkg::CntW-1:0]    slot;
  } bin_word_t;

  typedef struct packed {
    logic [rewr_pkg::CntW-1:0] bins_loaded;
    logic                      done_res;
    logic [rewr_pkg::CntW-1:0] edge_count;
    logic [rewr_pkg::CntW-1:0] edge_bin;
    logic                      edge_valid;
  } reply_t;

  // flavors of bin content used to build histograms
  typedef enum int unsigned {
    W_FINE,    // 0 .. 16.0, full fraction
    W_WIDE,    // any 32-bit value
    W_SPARSE,  // mostly small, many empty bins
    W_COUNTS   // whole counts 0 .. 6
  } wmode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic                          op_i = rewr_pkg::OP_LOAD;
  logic [rewr_pkg::WeightW-1:0]  bin_weight_i = '0;
  logic                          last_bin_i = 1'b0;
  logic [rewr_pkg::CntW-1:0]     edge_slot_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [rewr_pkg::CntW-1:0]     bins_loaded_o;
  logic                          done_res_o;
  logic [rewr_pkg::CntW-1:0]     edge_count_o;
  logic [rewr_pkg::CntW-1:0]     edge_bin_o;
  logic                          edge_valid_o;
  logic                          cfg_we_i = 1'b0;
  logic [rewr_pkg::CfgIdxW-1:0]  cfg_index_i = rewr_pkg::CFG_TARGET_GROUPS;
  logic [rewr_pkg::CfgDataW-1:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  reverse_equal_weight_rebinning dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .bin_weight_i  (bin_weight_i),
    .last_bin_i    (last_bin_i),
    .edge_slot_i   (edge_slot_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bins_loaded_o (bins_loaded_o),
    .done_res_o    (done_res_o),
    .edge_count_o  (edge_count_o),
    .edge_bin_o    (edge_bin_o),
    .edge_valid_o  (edge_valid_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  bin_word_t word_q[$];   // words waiting to be driven
  reply_t    reply_q[$];  // predicted replies, oldest first
  int unsigned queued  = 0;
  int unsigned err_cnt = 0;
  bit          no_gaps = 1'b0;  // set for a long stretch with no idling at all

  // ---------------------------------------------------------------------------
  // Predictor: shadow registers and storage
  // ---------------------------------------------------------------------------
  logic [rewr_pkg::GroupW-1:0]  tg_reg     = rewr_pkg::TargetGroupsReset;
  logic                         revise_reg = 1'b0;
  logic                         count_reg  = 1'b0;
  logic [rewr_pkg::WeightW-1:0] limit_reg  = rewr_pkg::SmallLimitReset;

  logic [rewr_pkg::WeightW-1:0] m_bins  [rewr_pkg::MaxBins];
  logic [rewr_pkg::CntW-1:0]    m_edges [rewr_pkg::EdgeDepth];
  int unsigned                  loaded_n = 0;
  logic [63:0]                  wsum     = '0;   // 42 bits used
  int unsigned                  edges_n  = 0;

  // Merge pass: walk from the top bin down, closing a group once it reaches the
  // target. Targets stay exact ratios num/den; every test is cross-multiplied.
  function automatic void merge_groups();
    int unsigned n;
    int unsigned cnt;
    int unsigned i;
    int unsigned high;
    int unsigned k;
    logic [63:0] groups;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] remaining;
    logic [63:0] sum;
    bit          share;
    bit          more;
    int unsigned desc [rewr_pkg::EdgeDepth];
    n      = loaded_n;
    groups = (tg_reg != '0) ? 64'(tg_reg) : 64'd1;
    share  = revise_reg || !count_reg;  // revise forces share mode
    num    = share ? wsum : (64'(tg_reg) << rewr_pkg::FracW);
    den    = share ? groups : 64'd1;
    cnt    = 0;
    if (n == 0) begin
      edges_n = 0;
      return;
    end
    // too light for two groups: keep the outer edges only
    if (wsum * den < 2 * num) begin
      m_edges[0] = '0;
      m_edges[1] = rewr_pkg::CntW'(n);
      edges_n = 2;
      return;
    end
    desc[cnt] = n;
    cnt++;
    remaining = wsum;
    sum = '0;
    i = n;
    while (i >= 1) begin
      if (revise_reg) num = remaining;
      sum  = 64'(m_bins[i-1]);
      high = i - 1;
      more = (sum * den <= num);
      while (more) begin
        if (i > 1) begin
          sum += 64'(m_bins[i-2]);
          high = i - 2;
          more = (sum * den < num);
          i--;
        end else begin
          high = i - 1;
          more = 1'b0;
        end
      end
      desc[cnt] = high;
      cnt++;
      remaining -= sum;
      i--;
    end
    // light bottom group folds into the one above, unless it is the only group
    if (cnt > 2 && sum < 64'(limit_reg)) begin
      desc[cnt-2] = desc[cnt-1];
      cnt--;
    end
    for (k = 0; k < cnt; k++) m_edges[k] = rewr_pkg::CntW'(desc[cnt-1-k]);
    edges_n = cnt;
  endfunction

  function automatic reply_t predict_reply(bin_word_t w);
    reply_t r;
    r = '0;
    if (w.op == rewr_pkg::OP_LOAD) begin
      // first load after a finished pass opens a new histogram
      if (edges_n != 0) begin
        loaded_n = 0;
        wsum     = '0;
        edges_n  = 0;
      end
      // full store drops the weight but still honors last_bin
      if (loaded_n < rewr_pkg::MaxBins) begin
        m_bins[loaded_n] = w.weight;
        loaded_n++;
        wsum += 64'(w.weight);
      end
      if (w.last) merge_groups();
    end else if (w.slot < edges_n && w.slot <= rewr_pkg::MaxBins) begin
      r.edge_bin   = m_edges[w.slot];
      r.edge_valid = 1'b1;
    end
    r.bins_loaded = rewr_pkg::CntW'(loaded_n);
    r.done_res    = (edges_n != 0);
    r.edge_count  = rewr_pkg::CntW'(edges_n);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one word per handshake, random gaps, valid held until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    bin_word_t nxt;
    reply_t    pred;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      op_i         <= rewr_pkg::OP_LOAD;
      bin_weight_i <= '0;
      last_bin_i   <= 1'b0;
      edge_slot_i  <= '0;
    end else begin
      // word taken at this edge: predict its reply from the held payload
      if (in_valid_i && in_ready_o) begin
        pred = predict_reply('{op: rewr_pkg::op_e'(op_i), weight: bin_weight_i,
                               last: last_bin_i, slot: edge_slot_i});
        reply_q.insert(reply_q.size(), pred);
      end
      if (!in_valid_i || in_ready_o) begin
        if (word_q.size() != 0 && (no_gaps || $urandom_range(99) >= 16)) begin
          nxt = word_q.pop_front();
          in_valid_i   <= 1'b1;
          op_i         <= nxt.op;
          bin_weight_i <= nxt.weight;
          last_bin_i   <= nxt.last;
          edge_slot_i  <= nxt.slot;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, every reply checked against the oldest
  // prediction
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t ns MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_replies
    reply_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (reply_q.size() == 0) begin
          flag_mismatch("reply with nothing pending, bins_loaded", bins_loaded_o, 0);
        end else begin
          want = reply_q.pop_front();
          if (bins_loaded_o !== want.bins_loaded)
            flag_mismatch("bins_loaded", bins_loaded_o, want.bins_loaded);
          if (done_res_o !== want.done_res)
            flag_mismatch("done_res", done_res_o, want.done_res);
          if (edge_count_o !== want.edge_count)
            flag_mismatch("edge_count", edge_count_o, want.edge_count);
          if (edge_bin_o !== want.edge_bin)
            flag_mismatch("edge_bin", edge_bin_o, want.edge_bin);
          if (edge_valid_o !== want.edge_valid)
            flag_mismatch("edge_valid", edge_valid_o, want.edge_valid);
        end
      end
      out_ready_i <= no_gaps || ($urandom_range(99) >= 16);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no word taken on either side means a hang
  // ---------------------------------------------------------------------------
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_load(logic [rewr_pkg::WeightW-1:0] w, bit last);
    bin_word_t wd;
    wd = '{op: rewr_pkg::OP_LOAD, weight: w, last: last, slot: '0};
    word_q.insert(word_q.size(), wd);
    queued++;
  endtask

  task automatic queue_read(int unsigned slot);
    bin_word_t wd;
    wd = '{op: rewr_pkg::OP_READ, weight: $urandom(), last: 1'($urandom_range(1)),
           slot: rewr_pkg::CntW'(slot)};
    word_q.insert(word_q.size(), wd);
    queued++;
  endtask

  function automatic logic [rewr_pkg::WeightW-1:0] pick_weight(wmode_e m);
    case (m)
      W_FINE:   return $urandom_range(32'h0010_0000);
      W_WIDE:   return $urandom();
      W_SPARSE: return ($urandom_range(3) == 0) ? '0 : $urandom_range(32'h0004_0000);
      default:  return rewr_pkg::WeightW'($urandom_range(6)) << rewr_pkg::FracW;
    endcase
  endfunction

  // n loads (last one flagged), an odd read slipped in mid-load, then edge reads
  task automatic queue_histogram(int unsigned n, wmode_e m);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 3) queue_read($urandom_range(n));
      queue_load(pick_weight(m), k == n - 1);
    end
    if (n <= 40) begin
      for (k = 0; k <= n + 1; k++) queue_read(k);
    end else begin
      queue_read(0);
      queue_read(n);
      repeat (24) queue_read($urandom_range(n + 1));
    end
    if ($urandom_range(3) == 0) queue_read($urandom_range(MaxSlot));
  endtask

  // registers change only here, with the block idle
  task automatic write_reg(rewr_pkg::cfg_idx_e idx, logic [rewr_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_regs(logic [rewr_pkg::GroupW-1:0] tg, bit rev, bit cnt,
                          logic [rewr_pkg::WeightW-1:0] lim);
    tg_reg     = tg;
    revise_reg = rev;
    count_reg  = cnt;
    limit_reg  = lim;
    write_reg(rewr_pkg::CFG_TARGET_GROUPS, rewr_pkg::CfgDataW'(tg));
    write_reg(rewr_pkg::CFG_REVISE_TARGET, rewr_pkg::CfgDataW'(rev));
    write_reg(rewr_pkg::CFG_USE_COUNT, rewr_pkg::CfgDataW'(cnt));
    write_reg(rewr_pkg::CFG_SMALL_LIMIT, rewr_pkg::CfgDataW'(lim));
  endtask

  task automatic pick_regs();
    logic [rewr_pkg::GroupW-1:0]  tg;
    logic [rewr_pkg::WeightW-1:0] lim;
    case ($urandom_range(5))
      0:       tg = '0;
      1:       tg = rewr_pkg::GroupW'($urandom_range(1, 4));
      2:       tg = rewr_pkg::GroupW'($urandom_range(5, 24));
      3:       tg = rewr_pkg::GroupW'(rewr_pkg::MaxBins);
      4:       tg = '1;
      default: tg = rewr_pkg::GroupW'($urandom_range(MaxSlot));
    endcase
    case ($urandom_range(3))
      0:       lim = '0;
      1:       lim = rewr_pkg::SmallLimitReset;
      2:       lim = '1;
      default: lim = $urandom();
    endcase
    set_regs(tg, $urandom_range(3) == 0, 1'($urandom_range(1)), lim);
  endtask

  // idle: nothing left to send, nothing in flight, then a short settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (word_q.size() != 0 || in_valid_i || reply_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned k;
    int unsigned n;
    bit          big_done;
    big_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reads before any pass, then a one-bin histogram at full scale (reset regs)
    queue_read(0);
    queue_read(MaxSlot);
    queue_load('1, 1'b1);
    for (k = 0; k < 3; k++) queue_read(k);
    wait_idle();

    // one group wanted: always too light, only outer edges; also load after pass
    set_regs(rewr_pkg::GroupW'(1), 1'b0, 1'b0, rewr_pkg::SmallLimitReset);
    queue_load(rewr_pkg::WeightW'(5) << rewr_pkg::FracW, 1'b0);
    queue_load('0, 1'b0);
    queue_load(rewr_pkg::WeightW'(7), 1'b1);
    for (k = 0; k < 3; k++) queue_read(k);
    wait_idle();

    // zero group count behaves as one
    set_regs('0, 1'b0, 1'b0, '0);
    queue_load(rewr_pkg::WeightW'(3) << rewr_pkg::FracW, 1'b0);
    queue_load(rewr_pkg::WeightW'(1) << rewr_pkg::FracW, 1'b1);
    for (k = 0; k < 3; k++) queue_read(k);
    wait_idle();

    // count mode, zero target, one empty bin: single group, small-group fold skipped
    set_regs('0, 1'b0, 1'b1, '1);
    queue_load('0, 1'b1);
    for (k = 0; k < 3; k++) queue_read(k);
    wait_idle();

    // random phases; one overfull histogram with no idling on either side
    while (queued < ItemTarget) begin
      if (!big_done && queued >= 500) begin
        no_gaps = 1'b1;
        pick_regs();
        queue_histogram(rewr_pkg::MaxBins + 6, W_WIDE);
        big_done = 1'b1;
        wait_idle();
        no_gaps = 1'b0;
      end else begin
        pick_regs();
        repeat ($urandom_range(2, 5)) begin
          n = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 16);
          queue_histogram(n, wmode_e'($urandom_range(3)));
          // loose words: stray loads, reads, early last_bin flags
          if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 4)) begin
              if ($urandom_range(1)) queue_read($urandom_range(MaxSlot));
              else queue_load($urandom(), $urandom_range(3) == 0);
            end
        end
        wait_idle();
      end
    end

    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rewr_pkg.sv
src/reverse_equal_weight_rebinning.sv
tb/sv/reverse_equal_weight_rebinning_tb.sv
